/* hw/rtl/ssmb_pkg.sv */
// Shared types, constants and the segment decode table for the display driver.
`default_nettype none

package ssmb_pkg;

  localparam int MaxDisplays = 8;
  localparam int DigitW      = $clog2(MaxDisplays);
  localparam int CountW      = $clog2(MaxDisplays + 1);
  localparam int PeriodW     = 24;
  localparam int CodeW       = 5;
  localparam int SegW        = 8;
  localparam int SelW        = 8;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 24;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumDisplays  = 3'd0,
    CfgCommonAnode  = 3'd1,
    CfgEnableMask   = 3'd2,
    CfgBlinkMask    = 3'd3,
    CfgRefreshPer   = 3'd4,
    CfgBlinkPer     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StReduce,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic refresh_hit;
    logic blink_hit;
  } div_stat_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic              wrap;
    logic              hit;
    logic [DigitW-1:0] cand;
  } scan_stat_t;

  // Segment levels a..g,p from bit 7 down; codes above the table show blank.
  function automatic logic [SegW-1:0] seg_pattern(input logic [CodeW-1:0] code);
    logic [SegW-1:0] pat;
    case (code)
      5'd0:    pat = 8'hFC;
      5'd1:    pat = 8'h60;
      5'd2:    pat = 8'hDA;
      5'd3:    pat = 8'hF2;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'hB6;
      5'd6:    pat = 8'hBE;
      5'd7:    pat = 8'hE0;
      5'd8:    pat = 8'hFE;
      5'd9:    pat = 8'hF6;
      5'd10:   pat = 8'hEE;
      5'd11:   pat = 8'h3E;
      5'd12:   pat = 8'h9C;
      5'd13:   pat = 8'h7A;
      5'd14:   pat = 8'h9E;
      5'd15:   pat = 8'h8E;
      5'd16:   pat = 8'hDE;
      5'd17:   pat = 8'h2A;
      5'd18:   pat = 8'h60;
      5'd19:   pat = 8'hF0;
      5'd20:   pat = 8'h1C;
      5'd21:   pat = 8'h2A;
      5'd22:   pat = 8'h3A;
      5'd23:   pat = 8'hCE;
      5'd24:   pat = 8'hE6;
      5'd25:   pat = 8'h0A;
      5'd26:   pat = 8'h1E;
      5'd27:   pat = 8'h38;
      5'd28:   pat = 8'h7C;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssmb_divider.sv */
// Refresh and blink tick dividers.
`default_nettype none

module ssmb_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [ssmb_pkg::PeriodW-1:0]  refresh_period_i,
  input  wire logic [ssmb_pkg::PeriodW-1:0]  blink_period_i,
  output ssmb_pkg::div_stat_t                stat_o
);

  logic [ssmb_pkg::PeriodW-1:0] refresh_count_q, refresh_count_d;
  logic [ssmb_pkg::PeriodW-1:0] blink_count_q, blink_count_d;
  logic [ssmb_pkg::PeriodW-1:0] refresh_next, blink_next;
  logic                         refresh_hit, blink_hit;

  always_comb begin
    refresh_next = refresh_count_q + ssmb_pkg::PeriodW'(1);
    blink_next   = blink_count_q + ssmb_pkg::PeriodW'(1);
    // wrap to zero counts as expiry too; a zero period fires every tick
    refresh_hit  = (refresh_next >= refresh_period_i) || (refresh_next == '0);
    blink_hit    = (blink_next >= blink_period_i) || (blink_next == '0);
    refresh_count_d = refresh_count_q;
    blink_count_d   = blink_count_q;
    if (tick_i) begin
      refresh_count_d = refresh_hit ? '0 : refresh_next;
      blink_count_d   = blink_hit ? '0 : blink_next;
    end
  end

  assign stat_o.refresh_hit = tick_i & refresh_hit;
  assign stat_o.blink_hit   = tick_i & blink_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_count_q <= '0;
      blink_count_q   <= '0;
    end else begin
      refresh_count_q <= refresh_count_d;
      blink_count_q   <= blink_count_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ssmb_scan.sv */
// Rotation scan: candidate register around one shared compare-subtract unit.
`default_nettype none

module ssmb_scan (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ssmb_pkg::scan_ctrl_t              ctrl_i,
  input  wire logic [ssmb_pkg::CountW-1:0]       start_i,
  input  wire logic [ssmb_pkg::CountW-1:0]       n_i,
  input  wire logic [ssmb_pkg::MaxDisplays-1:0]  mux_i,
  output ssmb_pkg::scan_stat_t                   stat_o
);

  logic [ssmb_pkg::CountW-1:0]      cand_q, cand_d;
  logic [ssmb_pkg::MaxDisplays-1:0] mux_q, mux_d;
  logic [ssmb_pkg::CountW-1:0]      unit_in, unit_out;
  logic                             unit_ge;

  // shared unit: v >= n ? v - n : v
  always_comb begin
    unit_in  = ctrl_i.step ? cand_q + ssmb_pkg::CountW'(1) : cand_q;
    unit_ge  = unit_in >= n_i;
    unit_out = unit_ge ? unit_in - n_i : unit_in;
  end

  always_comb begin
    cand_d = cand_q;
    mux_d  = mux_q;
    if (ctrl_i.load) begin
      cand_d = start_i;
      mux_d  = mux_i;
    end else if (ctrl_i.reduce || ctrl_i.step) begin
      cand_d = unit_out;
    end
  end

  assign stat_o.wrap = unit_ge;
  assign stat_o.hit  = mux_q[cand_q[ssmb_pkg::DigitW-1:0]];
  assign stat_o.cand = cand_q[ssmb_pkg::DigitW-1:0];

  // only the loaded flag needs reset; candidate and mask are payload
  logic loaded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (ctrl_i.load) begin
      loaded_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || loaded_q) begin
      cand_q <= cand_d;
      mux_q  <= mux_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/seven_segment_mux_blink_top.sv */
// Multiplexed seven-segment driver with blink: config, sequencer and result register.
// A write item or a tick without refresh passes through the emit state and is ready again after it.
// A refresh tick passes prep, then emit if no digit is lit, else reduce, scan and emit, one
// subtract or one scanned digit a cycle in the shared unit; emit holds while a result waits.
// Reset (async, active low) restores the register defaults, clears digits, counters and
// blink state, and shows nothing lit; it comes up ready with no result pending.
`default_nettype none

module seven_segment_mux_blink_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ssmb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ssmb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,  // digit_index[2:0], char_code[7:3]
  input  wire logic                            s_axis_tuser_i,  // cmd
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output      logic [15:0]                     m_axis_tdata_o,  // segments[7:0], digit_select[15:8]
  output      logic                            m_axis_tuser_o   // refreshed
);

  localparam int MaxD = ssmb_pkg::MaxDisplays;

  // configuration
  logic [3:0]                     num_displays_q;
  logic                           common_anode_q;
  logic [7:0]                     enable_mask_q;
  logic [7:0]                     blink_mask_q;
  logic [ssmb_pkg::PeriodW-1:0]   refresh_period_q;
  logic [ssmb_pkg::PeriodW-1:0]   blink_period_q;

  // display state
  logic [ssmb_pkg::CodeW-1:0]     digit_codes_q [MaxD];
  logic [ssmb_pkg::DigitW-1:0]    current_digit_q;
  logic                           blink_pending_q;
  logic                           blink_on_q;
  logic [ssmb_pkg::SegW-1:0]      shown_segments_q;
  logic [ssmb_pkg::SelW-1:0]      shown_select_q;
  logic                           refreshed_q;

  // result register
  logic                           m_valid_q;
  logic [15:0]                    m_data_q;
  logic                           m_user_q;

  ssmb_pkg::state_e               state_q, state_d;
  ssmb_pkg::div_stat_t            div_stat;
  ssmb_pkg::scan_ctrl_t           scan_ctrl;
  ssmb_pkg::scan_stat_t           scan_stat;

  logic                           s_accept;
  logic                           in_cmd;
  logic [ssmb_pkg::DigitW-1:0]    in_idx;
  logic [ssmb_pkg::CodeW-1:0]     in_code;
  logic                           out_free;
  logic                           emit_now;
  logic                           prep_blank;
  logic                           scan_done;

  logic [ssmb_pkg::CountW-1:0]    n_eff;
  logic [ssmb_pkg::CountW-1:0]    start_digit;
  logic                           blink_on_next;
  logic [MaxD:0]                  rot_full;
  logic [MaxD-1:0]                mux_prep;
  logic [ssmb_pkg::SegW-1:0]      polarity;

  assign in_cmd  = s_axis_tuser_i;
  assign in_idx  = s_axis_tdata_i[2:0];
  assign in_code = s_axis_tdata_i[7:3];

  assign s_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;

  // clamp the display count into 1..MaxD
  always_comb begin
    if (num_displays_q == '0) begin
      n_eff = ssmb_pkg::CountW'(1);
    end else if (ssmb_pkg::CountW'(num_displays_q) > ssmb_pkg::CountW'(MaxD)) begin
      n_eff = ssmb_pkg::CountW'(MaxD);
    end else begin
      n_eff = ssmb_pkg::CountW'(num_displays_q);
    end
  end

  always_comb begin
    blink_on_next = blink_on_q ^ blink_pending_q;
    rot_full      = ((MaxD + 1)'(1) << n_eff) - (MaxD + 1)'(1);
    mux_prep      = enable_mask_q[MaxD-1:0] & rot_full[MaxD-1:0];
    if (!blink_on_next) begin
      mux_prep = mux_prep & ~blink_mask_q[MaxD-1:0];
    end
    start_digit   = ssmb_pkg::CountW'(current_digit_q) + ssmb_pkg::CountW'(1);
    polarity      = {ssmb_pkg::SegW{common_anode_q}};
  end

  ssmb_divider u_divider (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (s_accept && (in_cmd == ssmb_pkg::CmdTick)),
    .refresh_period_i (refresh_period_q),
    .blink_period_i   (blink_period_q),
    .stat_o           (div_stat)
  );

  ssmb_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .start_i (start_digit),
    .n_i     (n_eff),
    .mux_i   (mux_prep),
    .stat_o  (scan_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssmb_pkg::StIdle: begin
        if (s_accept) begin
          if ((in_cmd == ssmb_pkg::CmdTick) && div_stat.refresh_hit) begin
            state_d = ssmb_pkg::StPrep;
          end else begin
            state_d = ssmb_pkg::StEmit;
          end
        end
      end
      ssmb_pkg::StPrep: begin
        state_d = (mux_prep == '0) ? ssmb_pkg::StEmit : ssmb_pkg::StReduce;
      end
      ssmb_pkg::StReduce: begin
        if (!scan_stat.wrap) begin
          state_d = ssmb_pkg::StScan;
        end
      end
      ssmb_pkg::StScan: begin
        if (scan_stat.hit) begin
          state_d = ssmb_pkg::StEmit;
        end
      end
      ssmb_pkg::StEmit: begin
        if (out_free) begin
          state_d = ssmb_pkg::StIdle;
        end
      end
      default: state_d = ssmb_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o  = 1'b0;
    scan_ctrl        = '0;
    emit_now         = 1'b0;
    prep_blank       = 1'b0;
    scan_done        = 1'b0;
    case (state_q)
      ssmb_pkg::StIdle:   s_axis_tready_o = 1'b1;
      ssmb_pkg::StPrep: begin
        scan_ctrl.load = 1'b1;
        prep_blank     = (mux_prep == '0);
      end
      ssmb_pkg::StReduce: scan_ctrl.reduce = 1'b1;
      ssmb_pkg::StScan: begin
        scan_done      = scan_stat.hit;
        scan_ctrl.step = ~scan_stat.hit;
      end
      ssmb_pkg::StEmit:   emit_now = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssmb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_displays_q   <= 4'd8;
      common_anode_q   <= 1'b0;
      enable_mask_q    <= 8'hFF;
      blink_mask_q     <= 8'h00;
      refresh_period_q <= 24'd2083;
      blink_period_q   <= 24'd1000000;
    end else if (cfg_we_i) begin
      case (ssmb_pkg::cfg_reg_e'(cfg_idx_i))
        ssmb_pkg::CfgNumDisplays: num_displays_q   <= cfg_data_i[3:0];
        ssmb_pkg::CfgCommonAnode: common_anode_q   <= cfg_data_i[0];
        ssmb_pkg::CfgEnableMask:  enable_mask_q    <= cfg_data_i[7:0];
        ssmb_pkg::CfgBlinkMask:   blink_mask_q     <= cfg_data_i[7:0];
        ssmb_pkg::CfgRefreshPer:  refresh_period_q <= cfg_data_i;
        ssmb_pkg::CfgBlinkPer:    blink_period_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // digit store; every 3-bit index lands inside the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxD; i++) begin
        digit_codes_q[i] <= '0;
      end
    end else if (s_accept && (in_cmd == ssmb_pkg::CmdWrite)) begin
      digit_codes_q[in_idx] <= in_code;
    end
  end

  // display and blink state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_digit_q  <= ssmb_pkg::DigitW'(1);
      blink_pending_q  <= 1'b0;
      blink_on_q       <= 1'b0;
      shown_segments_q <= '0;
      shown_select_q   <= '0;
      refreshed_q      <= 1'b0;
    end else begin
      if (s_accept) begin
        refreshed_q <= div_stat.refresh_hit;
        if (div_stat.blink_hit) begin
          blink_pending_q <= 1'b1;
        end
      end
      if (scan_ctrl.load) begin
        // latched blink expiry toggles the phase at this refresh
        blink_on_q      <= blink_on_next;
        blink_pending_q <= 1'b0;
      end
      if (prep_blank) begin
        shown_select_q   <= '0;
        shown_segments_q <= polarity;
      end
      if (scan_done) begin
        current_digit_q  <= scan_stat.cand;
        shown_select_q   <= ssmb_pkg::SelW'(1) << scan_stat.cand;
        shown_segments_q <= ssmb_pkg::seg_pattern(digit_codes_q[scan_stat.cand]) ^ polarity;
      end
    end
  end

  // result register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_now) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      m_data_q <= {shown_select_q, shown_segments_q};
      m_user_q <= refreshed_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

/* hw/rtl/ssmb_checker.sv */
// Port-level checks on the display driver, bound to the top level.
`default_nettype none

module ssmb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  logic       s_acc, m_acc;
  logic [1:0] outstanding_q, outstanding_d;

  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o & m_axis_tready_i;

  always_comb begin
    outstanding_d = outstanding_q + 2'(s_acc) - 2'(m_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken again straight after a beat");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> outstanding_q != 2'd0)
    else $error("result beat with no input outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 2'd2)
    else $error("more than two items in flight");

  a_dark_when_deselected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:8] == 8'h00) |->
      (m_axis_tdata_o[7:0] == 8'h00) || (m_axis_tdata_o[7:0] == 8'hFF))
    else $error("segments lit with no digit selected");

endmodule

bind seven_segment_mux_blink_top ssmb_checker u_ssmb_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking stream testbench for the blinking seven-segment display multiplexer.
`timescale 1ns / 1ps

module testbench;
  import ssmb_pkg::*;

  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems   = 36;
  localparam int unsigned GlyphCount   = 29;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [PeriodW-1:0] PeriodMax  = 24'hFFFFFF;

  // Segment patterns, character 28 in the top byte down to character 0 in the bottom one.
  localparam logic [GlyphCount*SegW-1:0] GlyphRom = {
    8'h7C, 8'h38, 8'h1E, 8'h0A, 8'hE6, 8'hCE, 8'h3A, 8'h2A, 8'h1C, 8'hF0,
    8'h60, 8'h2A, 8'hDE, 8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6,
    8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  typedef struct packed {
    logic [SegW-1:0] segments;
    logic [SelW-1:0] select;
    logic            refreshed;
  } frame_t;

  class display_scoreboard;
    logic [3:0]         digit_count;
    logic               anode;
    logic [7:0]         en_digits;
    logic [7:0]         blink_digits;
    logic [PeriodW-1:0] refresh_per;
    logic [PeriodW-1:0] blink_per;
    logic [CodeW-1:0]   codes [MaxDisplays];
    int unsigned        cur_digit;
    logic [PeriodW-1:0] refresh_cnt;
    logic [PeriodW-1:0] blink_cnt;
    logic               blink_due;
    logic               blink_lit;
    logic [SegW-1:0]    lit_segments;
    logic [SelW-1:0]    lit_select;
    frame_t             expected_frames [$];
    int unsigned        mismatches;

    function new();
      digit_count  = 4'd8;
      anode        = 1'b0;
      en_digits    = 8'hFF;
      blink_digits = 8'h00;
      refresh_per  = 24'd2083;
      blink_per    = 24'd1000000;
      foreach (codes[i]) codes[i] = '0;
      cur_digit    = 1;
      refresh_cnt  = '0;
      blink_cnt    = '0;
      blink_due    = 1'b0;
      blink_lit    = 1'b0;
      lit_segments = '0;
      lit_select   = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgNumDisplays: digit_count  = data[3:0];
        CfgCommonAnode: anode        = data[0];
        CfgEnableMask:  en_digits    = data[7:0];
        CfgBlinkMask:   blink_digits = data[7:0];
        CfgRefreshPer:  refresh_per  = data[PeriodW-1:0];
        CfgBlinkPer:    blink_per    = data[PeriodW-1:0];
        default: ;
      endcase
    endfunction

    function logic [SegW-1:0] glyph_level(logic [CodeW-1:0] code);
      logic [SegW-1:0] pat;
      int unsigned     pos;
      pos = code;
      pat = (pos < GlyphCount) ? GlyphRom[pos*SegW +: SegW] : '0;
      return anode ? ~pat : pat;
    endfunction

    // Flip the blink phase if due, then move to the next lit digit of the rotation, or blank if none is lit.
    function void rotate();
      int unsigned n;
      int unsigned cand;
      logic [31:0] live;
      n = digit_count;
      if (n == 0) n = 1;
      if (n > MaxDisplays) n = MaxDisplays;
      if (blink_due) begin
        blink_lit = !blink_lit;
        blink_due = 1'b0;
      end
      live = {24'h0, en_digits};
      if (!blink_lit) live = live & ~{24'h0, blink_digits};
      live = live & ((32'h1 << n) - 32'h1);
      if (live == 0) begin
        lit_select   = '0;
        lit_segments = anode ? '1 : '0;
        return;
      end
      cand = (cur_digit + 1) % n;
      while (!live[cand]) cand = (cand + 1) % n;
      cur_digit          = cand;
      lit_select         = '0;
      lit_select[cand]   = 1'b1;
      lit_segments       = glyph_level(codes[cand]);
    endfunction

    function void take_item(logic cmd, logic [DigitW-1:0] idx, logic [CodeW-1:0] code);
      frame_t f;
      f.refreshed = 1'b0;
      if (cmd == CmdWrite) begin
        codes[idx] = code;
      end else begin
        blink_cnt = blink_cnt + 1'b1;
        if (blink_cnt >= blink_per || blink_cnt == '0) begin
          blink_cnt = '0;
          blink_due = 1'b1;
        end
        refresh_cnt = refresh_cnt + 1'b1;
        if (refresh_cnt >= refresh_per || refresh_cnt == '0) begin
          refresh_cnt = '0;
          rotate();
          f.refreshed = 1'b1;
        end
      end
      f.segments = lit_segments;
      f.select   = lit_select;
      expected_frames.push_back(f);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no item outstanding");
        return;
      end
      want = expected_frames.pop_front();
      compare_field("segments", want.segments, got.segments);
      compare_field("digit_select", want.select, got.select);
      compare_field("refreshed", want.refreshed, got.refreshed);
    endfunction

    function void close_out();
      if (expected_frames.size() != 0) begin
        mismatches += expected_frames.size();
        $display("%0d results never arrived", expected_frames.size());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx        = '0;
  logic [CfgDataW-1:0] cfg_data       = '0;
  logic                item_valid     = 1'b0;
  logic [7:0]          item_data      = '0;
  logic                item_user      = 1'b0;
  logic                frame_ready    = 1'b0;
  wire                 item_ready;
  wire                 frame_valid;
  wire  [15:0]         frame_data;
  wire                 frame_user;
  int unsigned         send_idle_pct  = 12;
  int unsigned         recv_stall_pct = 76;
  int unsigned         quiet_cycles   = 0;
  display_scoreboard   book;

  seven_segment_mux_blink_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (item_valid),
    .s_axis_tready_o (item_ready),
    .s_axis_tdata_i  (item_data),
    .s_axis_tuser_i  (item_user),
    .m_axis_tvalid_o (frame_valid),
    .m_axis_tready_i (frame_ready),
    .m_axis_tdata_o  (frame_data),
    .m_axis_tuser_o  (frame_user)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (frame_valid && frame_ready)
      book.check_frame({frame_data[7:0], frame_data[15:8], frame_user});
    frame_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (frame_valid && frame_ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the beat until taken; valid stays high into the next item.
  task automatic push_item(input logic cmd, input logic [DigitW-1:0] idx,
                           input logic [CodeW-1:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= {code, idx};
    item_user  <= cmd;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    book.take_item(cmd, idx, code);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (book.expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    book.write_reg(idx, data);
  endtask

  task automatic configure(input logic [3:0] digits, input logic anode,
                           input logic [7:0] shown, input logic [7:0] blinking,
                           input logic [PeriodW-1:0] refresh_per,
                           input logic [PeriodW-1:0] blink_per);
    write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, CfgDataW'($urandom));
    write_reg(CfgNumDisplays, CfgDataW'(digits));
    write_reg(CfgCommonAnode, CfgDataW'(anode));
    write_reg(CfgEnableMask, CfgDataW'(shown));
    write_reg(CfgBlinkMask, CfgDataW'(blinking));
    write_reg(CfgRefreshPer, CfgDataW'(refresh_per));
    write_reg(CfgBlinkPer, CfgDataW'(blink_per));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CodeW-1:0] opening [8];
    opening = '{5'd0, 5'd31, 5'd9, 5'd28, 5'd29, 5'd15, 5'd16, 5'd27};
    book = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Refresh on every tick, blink expiring together with it every third tick.
    configure(4'd8, 1'b0, 8'hFF, 8'h5A, 24'd1, 24'd3);
    for (int i = 0; i < 8; i++) push_item(CmdWrite, DigitW'(i), opening[i]);
    for (int i = 0; i < 10; i++) push_item(CmdTick, DigitW'($urandom), CodeW'($urandom));
    drain();

    // Polarity flip: the latched pattern must stay as it was until the next refresh.
    configure(4'd8, 1'b1, 8'hFF, 8'h00, 24'd2, 24'd5);
    push_item(CmdTick, '0, '0);
    push_item(CmdWrite, 3'd0, 5'd8);
    push_item(CmdTick, '1, '1);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      send_idle_pct  = (p < 4) ? 12 : (p < 8) ? 76 : 0;
      recv_stall_pct = (p < 4) ? 76 : (p < 8) ? 12 : 0;
      case (p)
        0: configure(4'd0, 1'b0, 8'hFF, 8'h00, 24'd0, 24'd0);
        1: configure(4'd15, 1'b1, 8'($urandom), 8'hFF, 24'd1, PeriodMax);
        2: configure(4'd9, 1'b0, 8'h00, 8'($urandom), 24'd1, 24'd2);
        3: configure(4'd3, 1'b1, 8'hF8, 8'h00, 24'd2, 24'd1);
        4: configure(4'd1, 1'b0, 8'hFF, 8'h00, PeriodMax, 24'd1);
        5: configure(4'd8, 1'b1, 8'hFF, 8'hFF, 24'd1, 24'd2);
        default: configure(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                           8'($urandom), 8'($urandom),
                           PeriodW'($urandom_range(0, 4)), PeriodW'($urandom_range(0, 7)));
      endcase
      for (int i = 0; i < PhaseItems; i++)
        push_item(($urandom_range(0, 99) < 35) ? CmdWrite : CmdTick,
                  DigitW'($urandom), CodeW'($urandom));
      drain();
    end

    repeat (30) @(posedge clk);
    book.close_out();
    if (book.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ssmb_pkg.sv
hw/rtl/ssmb_divider.sv
hw/rtl/ssmb_scan.sv
hw/rtl/seven_segment_mux_blink_top.sv
hw/rtl/ssmb_checker.sv
dv/testbench.sv
